### sv/jcs_pkg.sv
// jcs_pkg: shared constants and types for the jsonc comment stripper
// no dependencies; used by jcs_scan.sv, jsonc_comment_stripper.sv and the testbench
`default_nettype none

package jcs_pkg;

    // character codes the scanner reacts to
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [Q_AW-1:0] t_qptr;
    typedef logic [Q_AW:0]   t_qcnt;

    // words produced by one scan step (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] data0;
        logic [7:0] data1;
    } t_emit;

    // one queued result word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_qent;

endpackage

`default_nettype wire

### sv/jcs_if.sv
// jcs_in_if / jcs_out_if: valid-ready channels of the jsonc comment stripper
// payload widths are fixed by the text format; no package dependency
`default_nettype none

interface jcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

interface jcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

### sv/jsonc_comment_stripper.sv
// jsonc_comment_stripper: streaming jsonc comment remover, top level
// depends on jcs_pkg, jcs_if (channel interfaces) and jcs_scan
`default_nettype none

// Takes a JSONC text one byte per input word and returns the text with // and
// /* */ comments removed; quoted strings pass untouched (a quote right after a
// backslash does not close a string). A slash is held until the next byte
// decides its meaning, so one input word yields zero, one or two output words;
// run_last marks the final output word of each input word. stream_end on an
// input word resets the scanner to plain text after that byte; a trailing
// slash is emitted and an unclosed comment swallows the rest of the stream.
// Rate: one input word per cycle while the queue has room for two words; an
// accepted word reaches the output through the input register, then the scan
// into the result queue. A four-word result queue sits between scanner and
// output; the scanner advances while the queue has room for two words, so
// the sustained rate is one word per cycle while the output is ready,
// limited by the one-word output when a held slash comes with its follower.

module jsonc_comment_stripper (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jcs_in_if.sink     i_in,
    jcs_out_if.source  o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // result queue
    jcs_pkg::t_qent r_q [jcs_pkg::Q_DEPTH];
    jcs_pkg::t_qptr r_wr_ptr, r_rd_ptr;
    jcs_pkg::t_qcnt r_count, n_count;

    jcs_pkg::t_emit emit;
    logic           room;      // queue can take a full two-word burst
    logic           step;      // scanner consumes the registered byte
    logic           in_take;
    logic           pop;
    logic [1:0]     push_cnt;

    assign room    = (r_count <= jcs_pkg::t_qcnt'(jcs_pkg::Q_DEPTH - 2));
    assign step    = r_in_valid && room;
    assign in_take = i_in.valid && i_in.ready;
    assign pop     = o_out.valid && o_out.ready;
    assign push_cnt = step ? emit.count : 2'd0;

    // input side ready does not look at the output handshake
    assign i_in.ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.text_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    jcs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_end),
        .o_emit  (emit)
    );

    // queue write: first word at the tail, second word just after it
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_wr_ptr].data <= emit.data0;
            r_q[r_wr_ptr].last <= (push_cnt == 2'd1);
        end
        if (push_cnt == 2'd2) begin
            r_q[jcs_pkg::t_qptr'(r_wr_ptr + 1'b1)].data <= emit.data1;
            r_q[jcs_pkg::t_qptr'(r_wr_ptr + 1'b1)].last <= 1'b1;
        end
    end

    assign n_count = r_count + jcs_pkg::t_qcnt'(push_cnt) - jcs_pkg::t_qcnt'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= jcs_pkg::t_qptr'(r_wr_ptr + push_cnt);
            if (pop) begin
                r_rd_ptr <= jcs_pkg::t_qptr'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    // output side straight from the queue head
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_byte = r_q[r_rd_ptr].data;
    assign o_out.run_last = r_q[r_rd_ptr].last;

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= jcs_pkg::t_qcnt'(jcs_pkg::Q_DEPTH))
        else $error("result queue over depth");

    // a scan step only happens with room for a two-word burst
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> (r_count <= jcs_pkg::t_qcnt'(jcs_pkg::Q_DEPTH - 2)))
        else $error("scan step without queue room");

    // occupancy tracks pushes and pops exactly
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(n_count)))
        else $error("queue occupancy mismatch");

    // every word that reaches the output side came from an accepted byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt != 2'd0) |-> r_in_valid)
        else $error("result word without input byte");

endmodule

`default_nettype wire

### sv/jcs_scan.sv
// jcs_scan: comment scanner state machine, one raw byte per step
// depends on jcs_pkg for character codes and the t_emit struct
`default_nettype none

module jcs_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output jcs_pkg::t_emit     o_emit
);

    typedef enum logic [2:0] {
        S_NORMAL     = 3'd0,
        S_STRING     = 3'd1,
        S_SLASH_HELD = 3'd2,
        S_LINE       = 3'd3,
        S_BLOCK      = 3'd4,
        S_BLOCK_STAR = 3'd5
    } t_mode;

    t_mode r_mode, n_mode;
    logic  r_prior_bs, n_prior_bs;

    logic  is_quote, is_slash, is_star, is_nl;
    logic  norm_emit;
    t_mode norm_mode;

    assign is_quote = (i_byte == jcs_pkg::CH_QUOTE);
    assign is_slash = (i_byte == jcs_pkg::CH_SLASH);
    assign is_star  = (i_byte == jcs_pkg::CH_STAR);
    assign is_nl    = (i_byte == jcs_pkg::CH_NEWLINE);

    // plain-text handling: slash is held unless it ends the stream
    assign norm_emit = !(is_slash && !i_last);
    assign norm_mode = is_quote ? S_STRING :
                       (is_slash && !i_last) ? S_SLASH_HELD : S_NORMAL;

    always_comb begin
        n_mode       = r_mode;
        o_emit.count = 2'd0;
        o_emit.data0 = i_byte;
        o_emit.data1 = i_byte;
        unique case (r_mode)
            S_STRING: begin
                o_emit.count = 2'd1;
                if (is_quote && !r_prior_bs) begin
                    n_mode = S_NORMAL;
                end
            end
            S_SLASH_HELD: begin
                if (is_slash) begin
                    n_mode = S_LINE;
                end else if (is_star) begin
                    n_mode = S_BLOCK;
                end else begin
                    // release held slash, then the byte as plain text
                    o_emit.data0 = jcs_pkg::CH_SLASH;
                    o_emit.count = norm_emit ? 2'd2 : 2'd1;
                    n_mode       = norm_mode;
                end
            end
            S_LINE: begin
                if (is_nl) begin
                    n_mode = S_NORMAL;
                end
            end
            S_BLOCK: begin
                if (is_star) begin
                    n_mode = S_BLOCK_STAR;
                end
            end
            S_BLOCK_STAR: begin
                if (is_slash) begin
                    n_mode = S_NORMAL;
                end else if (!is_star) begin
                    n_mode = S_BLOCK;
                end
            end
            default: begin
                o_emit.count = norm_emit ? 2'd1 : 2'd0;
                n_mode       = norm_mode;
            end
        endcase
        n_prior_bs = (i_byte == jcs_pkg::CH_BACKSLASH);
        if (i_last) begin
            n_mode     = S_NORMAL;
            n_prior_bs = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= S_NORMAL;
            r_prior_bs <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_prior_bs <= n_prior_bs;
        end
    end

endmodule

`default_nettype wire

### tb/jcs_strip_checker.sv
`timescale 1ns / 100ps
// jcs_strip_checker: watches both channels of the jsonc comment stripper
// predicts the comment-free word stream; depends on jcs_pkg and jcs_if

module jcs_strip_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jcs_in_if    i_in_mon,
    jcs_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_bytes_in,
    output int   o_words_out,
    output int   o_strings,
    output int   o_line_cmts,
    output int   o_block_cmts
);

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_STRING,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BLOCK_STAR
    } t_scan_st;

    t_scan_st       scan_st;
    logic           after_bs;
    jcs_pkg::t_qent stripped_q[$];

    // one raw byte through the scanner, expected words go to stripped_q
    task automatic strip_step(input logic [7:0] b, input logic fin);
        jcs_pkg::t_qent words[2];
        int    n;
        logic  as_text;
        n       = 0;
        as_text = 1'b0;
        case (scan_st)
            SCAN_STRING: begin
                words[n].data = b;
                n++;
                if (b == jcs_pkg::CH_QUOTE && !after_bs) begin
                    scan_st = SCAN_TEXT;
                end
            end
            SCAN_SLASH: begin
                if (b == jcs_pkg::CH_SLASH) begin
                    scan_st = SCAN_LINE;
                    o_line_cmts++;
                end else if (b == jcs_pkg::CH_STAR) begin
                    scan_st = SCAN_BLOCK;
                    o_block_cmts++;
                end else begin
                    // held slash released, follower handled as plain text
                    words[n].data = jcs_pkg::CH_SLASH;
                    n++;
                    as_text = 1'b1;
                end
            end
            SCAN_LINE: begin
                if (b == jcs_pkg::CH_NEWLINE) begin
                    scan_st = SCAN_TEXT;
                end
            end
            SCAN_BLOCK: begin
                if (b == jcs_pkg::CH_STAR) begin
                    scan_st = SCAN_BLOCK_STAR;
                end
            end
            SCAN_BLOCK_STAR: begin
                if (b == jcs_pkg::CH_SLASH) begin
                    scan_st = SCAN_TEXT;
                end else if (b != jcs_pkg::CH_STAR) begin
                    scan_st = SCAN_BLOCK;
                end
            end
            default: begin
                as_text = 1'b1;
            end
        endcase

        if (as_text) begin
            if (b == jcs_pkg::CH_QUOTE) begin
                scan_st = SCAN_STRING;
                words[n].data = b;
                n++;
                o_strings++;
            end else if (b == jcs_pkg::CH_SLASH && !fin) begin
                scan_st = SCAN_SLASH;
            end else begin
                // includes a slash that ends the stream
                scan_st = SCAN_TEXT;
                words[n].data = b;
                n++;
            end
        end

        after_bs = (b == jcs_pkg::CH_BACKSLASH);
        if (fin) begin
            scan_st  = SCAN_TEXT;
            after_bs = 1'b0;
        end

        for (int k = 0; k < n; k++) begin
            words[k].last = (k == n - 1);
            stripped_q.insert(stripped_q.size(), words[k]);
        end
    endtask

    always @(posedge i_clk) begin
        jcs_pkg::t_qent want;
        if (!i_rst_n) begin
            scan_st  = SCAN_TEXT;
            after_bs = 1'b0;
            stripped_q.delete();
            o_fail_count = 0;
            o_bytes_in   = 0;
            o_words_out  = 0;
            o_strings    = 0;
            o_line_cmts  = 0;
            o_block_cmts = 0;
        end else begin
            // output first: a word leaving now never stems from a byte entering now
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_words_out++;
                if (stripped_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word, expected none, actual byte %h last %b",
                             $time, i_out_mon.out_byte, i_out_mon.run_last);
                end else begin
                    want = stripped_q.pop_front();
                    if (want.data !== i_out_mon.out_byte) begin
                        o_fail_count++;
                        $display("%0t: out_byte mismatch, expected %h, actual %h",
                                 $time, want.data, i_out_mon.out_byte);
                    end
                    if (want.last !== i_out_mon.run_last) begin
                        o_fail_count++;
                        $display("%0t: run_last mismatch, expected %b, actual %b (byte %h)",
                                 $time, want.last, i_out_mon.run_last, want.data);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                o_bytes_in++;
                strip_step(i_in_mon.text_byte, i_in_mon.stream_end);
            end
        end
        o_pending = stripped_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: top of the jsonc comment stripper testbench, drives text and gives the verdict
// depends on jcs_pkg, jcs_if, jsonc_comment_stripper and jcs_strip_checker

module tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int BYTE_TARGET    = 1330;  // input bytes in the random part
    localparam int IDLE_PCT       = 38;
    localparam int RX_HOLD_CYCLES = 300;   // long output stall, fills the result queue
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any word moving
    localparam int DRAIN_CYCLES   = 10;    // input register + scan, with margin

    logic i_clk = 1'b0;
    logic i_rst_n;

    jcs_in_if  in_ch ();
    jcs_out_if out_ch ();

    // shared between the sender and receiver processes
    bit gaps_on     = 1'b1;
    bit rx_hold_req = 1'b0;

    int fail_count, pending, bytes_in, words_out, n_strings, n_line, n_block;
    int sent_bytes;
    int idle_cycles = 0;

    logic [7:0] doc_bytes[$];

    jsonc_comment_stripper DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    jcs_strip_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes_in   (bytes_in),
        .o_words_out  (words_out),
        .o_strings    (n_strings),
        .o_line_cmts  (n_line),
        .o_block_cmts (n_block)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // offer one byte from a falling edge, hold it until taken at a rising edge;
    // returns on the falling edge after the handshake
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.text_byte  <= b;
        in_ch.stream_end <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], fin_last && (k == s.len() - 1));
        end
    endtask

    // lower-case letters for plain text, or a mix with the scanner's marks
    function automatic logic [7:0] pick_char(input bit with_marks);
        logic [7:0] marks[5] = '{jcs_pkg::CH_QUOTE, jcs_pkg::CH_BACKSLASH,
                                 jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR,
                                 jcs_pkg::CH_NEWLINE};
        int         r;
        r = $urandom_range(0, 99);
        if (!with_marks || r < 45) begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end else if (r < 75) begin
            return marks[$urandom_range(0, 4)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // add one byte at the end of the current text
    function automatic void append_doc(input logic [7:0] b);
        doc_bytes = {doc_bytes, b};
    endfunction

    // one text of random tokens: mostly well formed strings and comments, some noise;
    // returns its length in bytes
    function automatic int build_doc();
        int         r, len;
        logic [7:0] c;
        doc_bytes.delete();
        repeat ($urandom_range(3, 10)) begin
            r   = $urandom_range(0, 99);
            len = $urandom_range(0, 6);
            if (r < 25) begin
                repeat (len + 1) append_doc(pick_char(1'b0));
            end else if (r < 45) begin
                // string: bare quotes inside get a backslash, comment marks stay literal
                append_doc(jcs_pkg::CH_QUOTE);
                repeat (len) begin
                    c = pick_char(1'b1);
                    if (c == jcs_pkg::CH_QUOTE) begin
                        append_doc(jcs_pkg::CH_BACKSLASH);
                    end
                    append_doc(c);
                end
                append_doc(jcs_pkg::CH_QUOTE);
            end else if (r < 60) begin
                append_doc(jcs_pkg::CH_SLASH);
                append_doc(jcs_pkg::CH_SLASH);
                repeat (len) append_doc(pick_char(1'b1));
                append_doc(jcs_pkg::CH_NEWLINE);
            end else if (r < 78) begin
                append_doc(jcs_pkg::CH_SLASH);
                append_doc(jcs_pkg::CH_STAR);
                repeat (len) append_doc(pick_char(1'b1));
                if ($urandom_range(0, 2) == 0) begin
                    append_doc(jcs_pkg::CH_STAR);
                end
                append_doc(jcs_pkg::CH_STAR);
                append_doc(jcs_pkg::CH_SLASH);
            end else if (r < 88) begin
                // lone slash, usually released together with its follower
                append_doc(jcs_pkg::CH_SLASH);
                append_doc(pick_char(1'b1));
            end else begin
                repeat (len + 1) append_doc(8'($urandom_range(0, 255)));
            end
        end
        return doc_bytes.size();
    endfunction

    // receiver: random ready, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
                @(negedge i_clk);
            end
        end
    end

    // watchdog: only handshakes count as progress
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no word moved for %0d cycles, %0d words still due",
                         $time, idle_cycles, pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int doc_idx;
        in_ch.valid      <= 1'b0;
        in_ch.text_byte  <= 8'h00;
        in_ch.stream_end <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // held slash then quote: slash comes out, quote opens a string;
        // backslash-quote stays inside, the last quote closes it
        send_text("/\"\\\"q\"", 1'b0);
        // line comment through its newline
        send_text("//c\n", 1'b0);
        // the opener's star cannot close; a run of stars then slash does
        send_text("/*/**/", 1'b0);
        // slash as last byte of the stream is emitted
        send_text("x/", 1'b1);
        // unclosed block comment swallows the end of the stream
        send_text("/*z", 1'b1);
        // quote on the last byte: string dropped again by the stream end
        send_byte(jcs_pkg::CH_QUOTE, 1'b1);

        // random texts, each closed by a stream_end byte
        sent_bytes = 0;
        doc_idx    = 0;
        while (sent_bytes < BYTE_TARGET) begin
            if (doc_idx == 4) begin
                rx_hold_req = 1'b1;     // sender keeps offering while output stalls
            end
            gaps_on = !(doc_idx >= 12 && doc_idx < 24);
            sent_bytes += build_doc();
            foreach (doc_bytes[k]) begin
                send_byte(doc_bytes[k], k == doc_bytes.size() - 1);
            end
            doc_idx++;
        end
        in_ch.valid <= 1'b0;
        gaps_on = 1'b1;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        // a swallowed byte may still be in flight with nothing due
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run: %0d bytes in over %0d random texts, %0d words out checked",
                 bytes_in, doc_idx, words_out);
        $display("Run: %0d strings, %0d line comments, %0d block comments seen",
                 n_strings, n_line, n_block);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
